// ----- rtl/cca_pkg.sv -----
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the coulomb charge accumulator: the request
// and response beat layouts, item kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package cca_pkg;

   localparam int TIME_BITS   = 32;
   localparam int SAMPLE_BITS = 10;
   localparam int CFG_BITS    = 16;
   localparam int OUT_BITS    = 32;
   localparam int COUNT_BITS_DEFAULT = 32;

   // item kinds
   localparam logic KIND_POLL      = 1'b0;
   localparam logic KIND_DAY_RESET = 1'b1;

   // register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_MS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINE_UNIT   = 1'd1;

   localparam logic [CFG_BITS-1:0] INTERVAL_MS_RESET = 16'd20;
   localparam logic [CFG_BITS-1:0] FINE_UNIT_RESET   = 16'd1000;

   typedef struct packed {
      logic                   kind;
      logic [TIME_BITS-1:0]   now_ms;
      logic [SAMPLE_BITS-1:0] charge_sample;
      logic [SAMPLE_BITS-1:0] discharge_sample;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0]        charge_count;
      logic [OUT_BITS-1:0]        discharge_count;
      logic signed [OUT_BITS-1:0] remaining_count;
      logic [OUT_BITS-1:0]        elapsed_ms;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] interval_ms;
      logic [CFG_BITS-1:0] fine_unit;
   } cfg_type;

endpackage

// ----- rtl/coulomb_charge_accumulator.sv -----
// ----------------------------------------------------------------------------
// coulomb_charge_accumulator
// Coulomb counter integrating charge and discharge current samples into
// fine sums and coarse counts, with a day reset capturing the balance.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_valid / req_stall / req_data. A beat is a poll (time and
//   two current samples) or a day reset. Each beat yields one rsp beat.
//   rsp channel: rsp_valid / rsp_stall / rsp_data with the coarse counts,
//   the balance captured at the last day reset and the elapsed tick time.
//   csr channel: csr_valid / csr_ready / csr_index / csr_data writes the
//   interval (index 0) and fine unit (index 1); csr_ready is always high.
//   Write it only while no beat is in flight.
// Timing: a request beat is registered in the input stage, processed by
//   combinational logic against the accumulator registers and lands in the
//   response register, so rsp_valid rises once the beat has passed the input
//   register and then the response register. One beat per cycle is sustained
//   while rsp_stall is low; the state update loop is combinational.
// Reset: synchronous; empties both stages, clears all sums and counts and
//   loads interval 20 and fine unit 1000.
// Stall: a stalled response holds; the input stage then fills and req_stall
//   rises, so at most one further beat is taken while the output waits.
// ----------------------------------------------------------------------------
module coulomb_charge_accumulator import cca_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   cfg_type cfg;
   req_type item_ff, item_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type result;
   logic    fire;
   logic    in_take;

   cca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cca_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // input stage moves on when the output register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign in_take   = req_valid && !req_stall;

   always_comb begin
      item_in      = in_take ? req_data : item_ff;
      in_valid_in  = in_take || (in_valid_ff && !fire);
      out_data_in  = fire ? result : out_data_ff;
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty input stage");

   a_blocked_output_stalls: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("input not held off while output is blocked");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed beat did not reach the response register");
`endif

endmodule

// ----- rtl/cca_csr.sv -----
// ----------------------------------------------------------------------------
// cca_csr
// Configuration registers: tick interval and fine unit, written one beat at
// a time through the csr channel, which never holds off a write.
// ----------------------------------------------------------------------------
module cca_csr import cca_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL_MS: cfg_in.interval_ms = csr_data;
            CSR_FINE_UNIT:   cfg_in.fine_unit   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms <= INTERVAL_MS_RESET;
         cfg_ff.fine_unit   <= FINE_UNIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/cca_core.sv -----
// ----------------------------------------------------------------------------
// cca_core
// Accumulator state and the combinational update for one item: tick and
// sample integration, fine-to-coarse transfer and the day reset.
// ----------------------------------------------------------------------------
module cca_core import cca_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int PROD_BITS = SAMPLE_BITS + CFG_BITS;

   logic [TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [TIME_BITS-1:0]  tick_time_ff, tick_time_in;
   logic [COUNT_BITS-1:0] charge_fine_ff, charge_fine_in;
   logic [COUNT_BITS-1:0] discharge_fine_ff, discharge_fine_in;
   logic [COUNT_BITS-1:0] charge_total_ff, charge_total_in;
   logic [COUNT_BITS-1:0] discharge_total_ff, discharge_total_in;
   logic [COUNT_BITS-1:0] remaining_total_ff, remaining_total_in;

   logic [TIME_BITS-1:0]  since;
   logic [PROD_BITS-1:0]  charge_prod;
   logic [PROD_BITS-1:0]  discharge_prod;
   logic [COUNT_BITS-1:0] unit;

   assign since          = item.now_ms - tick_time_ff;
   assign charge_prod    = PROD_BITS'(item.charge_sample) * PROD_BITS'(cfg.interval_ms);
   assign discharge_prod = PROD_BITS'(item.discharge_sample) * PROD_BITS'(cfg.interval_ms);
   assign unit           = COUNT_BITS'(cfg.fine_unit);

   always_comb begin
      start_time_in      = start_time_ff;
      tick_time_in       = tick_time_ff;
      charge_fine_in     = charge_fine_ff;
      discharge_fine_in  = discharge_fine_ff;
      charge_total_in    = charge_total_ff;
      discharge_total_in = discharge_total_ff;
      remaining_total_in = remaining_total_ff;
      if (item.kind == KIND_DAY_RESET) begin
         remaining_total_in = charge_total_ff - discharge_total_ff;
         charge_total_in    = '0;
         discharge_total_in = '0;
         charge_fine_in     = '0;
         discharge_fine_in  = '0;
         tick_time_in       = item.now_ms;
         start_time_in      = item.now_ms;
      end else if (since > TIME_BITS'(cfg.interval_ms)) begin
         // products wrap into the fine sums like the sums themselves
         charge_fine_in    = charge_fine_ff + COUNT_BITS'(charge_prod);
         discharge_fine_in = discharge_fine_ff + COUNT_BITS'(discharge_prod);
         tick_time_in      = tick_time_ff + TIME_BITS'(cfg.interval_ms);
      end else if (charge_fine_ff > unit) begin
         charge_total_in = charge_total_ff + COUNT_BITS'(1);
         charge_fine_in  = charge_fine_ff - unit;
      end else if (discharge_fine_ff > unit) begin
         discharge_total_in = discharge_total_ff + COUNT_BITS'(1);
         discharge_fine_in  = discharge_fine_ff - unit;
      end
   end

   // result shows the state after this item
   always_comb begin
      result.charge_count    = OUT_BITS'(charge_total_in);
      result.discharge_count = OUT_BITS'(discharge_total_in);
      result.remaining_count = OUT_BITS'(remaining_total_in);
      result.elapsed_ms      = OUT_BITS'(tick_time_in - start_time_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff      <= '0;
         tick_time_ff       <= '0;
         charge_fine_ff     <= '0;
         discharge_fine_ff  <= '0;
         charge_total_ff    <= '0;
         discharge_total_ff <= '0;
         remaining_total_ff <= '0;
      end else if (fire) begin
         start_time_ff      <= start_time_in;
         tick_time_ff       <= tick_time_in;
         charge_fine_ff     <= charge_fine_in;
         discharge_fine_ff  <= discharge_fine_in;
         charge_total_ff    <= charge_total_in;
         discharge_total_ff <= discharge_total_in;
         remaining_total_ff <= remaining_total_in;
      end
   end

endmodule
